/* hw/rtl/mkld_pkg.sv */
`timescale 1ns / 1ps

package mkld_pkg;

    localparam int MAX_SYMBOLS = 5;
    localparam int SYM_CNT_W   = $clog2(MAX_SYMBOLS + 1);
    localparam int TICK_W      = 16;
    localparam int LETTERS     = 26;
    localparam int INDEX_W     = 5;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_PRESS   = 2'd1;
    localparam logic [1:0] PH_GAP     = 2'd2;
    localparam logic [1:0] PH_DISPLAY = 2'd3;

    localparam logic [1:0] REG_DASH    = 2'd0;
    localparam logic [1:0] REG_GAP     = 2'd1;
    localparam logic [1:0] REG_DISPLAY = 2'd2;

    localparam logic [TICK_W-1:0] DASH_RESET    = 16'd250;
    localparam logic [TICK_W-1:0] GAP_RESET     = 16'd1000;
    localparam logic [TICK_W-1:0] DISPLAY_RESET = 16'd1000;
    localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;

    // Morse table, A..Z; symbol k is bit k, 1 for dash
    localparam logic [2:0] CODE_LEN [LETTERS] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
        3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
    };
    localparam logic [3:0] CODE_BITS [LETTERS] = '{
        4'd2, 4'd1, 4'd5, 4'd1, 4'd0, 4'd4, 4'd3, 4'd0, 4'd0, 4'd14, 4'd5, 4'd2, 4'd3,
        4'd1, 4'd7, 4'd6, 4'd11, 4'd2, 4'd0, 4'd1, 4'd4, 4'd8, 4'd6, 4'd9, 4'd13, 4'd3
    };

    typedef struct packed {
        logic [1:0]             phase;
        logic [TICK_W-1:0]      tick_count;
        logic [MAX_SYMBOLS-1:0] symbol_bits;
        logic [SYM_CNT_W-1:0]   symbol_count;
        logic                   overflowed;
        logic                   display_lamp;
    } t_state;

    typedef struct packed {
        logic [TICK_W-1:0] dash_ticks;
        logic [TICK_W-1:0] letter_gap_ticks;
        logic [TICK_W-1:0] display_ticks;
    } t_cfg;

    typedef struct packed {
        logic [INDEX_W-1:0] letter_index;
        logic               letter_found;
        logic               letter_done;
        logic               lamp_b;
        logic               lamp_a;
        logic               buzzer;
    } t_result;

endpackage

/* hw/rtl/morse_key_letter_decoder.sv */
`timescale 1ns / 1ps

// Channel   | Direction | Payload
// s_axis    | in        | tdata[0] key_down, tdata[7:1] zero
// m_axis    | out       | tdata[0] buzzer, [1] lamp_a, [2] lamp_b, [3] letter_done,
//           |           | [4] letter_found, [9:5] letter_index, [15:10] zero
// apb       | in        | 0x0 dash_ticks, 0x4 letter_gap_ticks, 0x8 display_ticks
//
// One item per cycle while not stalled: each accepted item yields one result in
// the output register the next cycle. Synchronous active-low reset clears the
// letter state and the output valid, and loads the default thresholds. A
// stalled output holds its result; input is still taken in the cycle it leaves.

module morse_key_letter_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] key_down
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // buzzer, lamp_a, lamp_b, letter_done,
                                        // letter_found, letter_index[4:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    mkld_pkg::t_state  r_state;
    mkld_pkg::t_state  n_state;
    mkld_pkg::t_cfg    r_cfg;
    mkld_pkg::t_result n_result;
    mkld_pkg::t_result r_result;
    logic              r_out_valid;
    logic              w_accept;
    logic              w_cfg_wr;
    logic [1:0]        w_reg_sel;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_reg_sel = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dash_ticks       <= mkld_pkg::DASH_RESET;
            r_cfg.letter_gap_ticks <= mkld_pkg::GAP_RESET;
            r_cfg.display_ticks    <= mkld_pkg::DISPLAY_RESET;
        end else if (w_cfg_wr) begin
            unique case (w_reg_sel)
                mkld_pkg::REG_DASH:    r_cfg.dash_ticks       <= pwdata[15:0];
                mkld_pkg::REG_GAP:     r_cfg.letter_gap_ticks <= pwdata[15:0];
                mkld_pkg::REG_DISPLAY: r_cfg.display_ticks    <= pwdata[15:0];
                default: begin
                    // drop writes past the register list
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_sel)
            mkld_pkg::REG_DASH:    prdata = {16'd0, r_cfg.dash_ticks};
            mkld_pkg::REG_GAP:     prdata = {16'd0, r_cfg.letter_gap_ticks};
            mkld_pkg::REG_DISPLAY: prdata = {16'd0, r_cfg.display_ticks};
            default:               prdata = '0;
        endcase
    end

    mkld_step u_step (
        .i_state    (r_state),
        .i_cfg      (r_cfg),
        .i_key_down (s_axis_tdata[0]),
        .o_state    (n_state),
        .o_result   (n_result)
    );

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_state <= n_state;
            end
            if (s_axis_tready) begin
                r_out_valid <= s_axis_tvalid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_result};

endmodule

/* hw/rtl/mkld_step.sv */
`timescale 1ns / 1ps

module mkld_step (
    input  mkld_pkg::t_state  i_state,
    input  mkld_pkg::t_cfg    i_cfg,
    input  logic              i_key_down,
    output mkld_pkg::t_state  o_state,
    output mkld_pkg::t_result o_result
);

    logic [mkld_pkg::TICK_W-1:0]  w_bumped;
    logic                         w_match;
    logic [mkld_pkg::INDEX_W-1:0] w_match_idx;

    assign w_bumped = (i_state.tick_count != mkld_pkg::TICK_MAX)
                    ? i_state.tick_count + 1'b1 : i_state.tick_count;

    // Table search; codes are unique, lowest index wins anyway
    always_comb begin
        w_match     = 1'b0;
        w_match_idx = '0;
        for (int i = mkld_pkg::LETTERS - 1; i >= 0; i--) begin
            if ({1'b0, mkld_pkg::CODE_LEN[i]} == 4'(i_state.symbol_count) &&
                5'(mkld_pkg::CODE_BITS[i]) == 5'(i_state.symbol_bits)) begin
                w_match     = 1'b1;
                w_match_idx = mkld_pkg::INDEX_W'(i);
            end
        end
    end

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (i_key_down) begin
            if (i_state.phase != mkld_pkg::PH_PRESS) begin
                if (i_state.phase != mkld_pkg::PH_GAP) begin
                    o_state.symbol_bits  = '0;
                    o_state.symbol_count = '0;
                    o_state.overflowed   = 1'b0;
                end
                o_state.phase      = mkld_pkg::PH_PRESS;
                o_state.tick_count = mkld_pkg::TICK_W'(1);
            end else begin
                o_state.tick_count = w_bumped;
            end
            o_result.buzzer = 1'b1;
            if (o_state.tick_count >= i_cfg.dash_ticks) begin
                o_result.lamp_b = 1'b1;
            end else begin
                o_result.lamp_a = 1'b1;
            end
        end else begin
            unique case (i_state.phase)
                mkld_pkg::PH_PRESS: begin
                    // append the symbol, or drop it once the buffer is full
                    if (i_state.symbol_count < mkld_pkg::SYM_CNT_W'(mkld_pkg::MAX_SYMBOLS)) begin
                        if (i_state.tick_count >= i_cfg.dash_ticks) begin
                            o_state.symbol_bits[i_state.symbol_count] = 1'b1;
                        end
                        o_state.symbol_count = i_state.symbol_count + 1'b1;
                    end else begin
                        o_state.overflowed = 1'b1;
                    end
                    o_state.phase      = mkld_pkg::PH_GAP;
                    o_state.tick_count = '0;
                end
                mkld_pkg::PH_GAP: begin
                    o_state.tick_count = w_bumped;
                    if (w_bumped >= i_cfg.letter_gap_ticks) begin
                        o_result.letter_done = 1'b1;
                        if (!i_state.overflowed && w_match) begin
                            o_result.letter_found = 1'b1;
                            o_result.letter_index = w_match_idx;
                        end
                        o_state.display_lamp = !o_result.letter_found;
                        o_state.symbol_bits  = '0;
                        o_state.symbol_count = '0;
                        o_state.overflowed   = 1'b0;
                        if (i_cfg.display_ticks == '0) begin
                            o_state.phase      = mkld_pkg::PH_IDLE;
                            o_state.tick_count = '0;
                        end else begin
                            o_state.phase      = mkld_pkg::PH_DISPLAY;
                            o_state.tick_count = mkld_pkg::TICK_W'(1);
                            o_result.lamp_b    = !o_result.letter_found;
                            o_result.lamp_a    = o_result.letter_found;
                        end
                    end
                end
                mkld_pkg::PH_DISPLAY: begin
                    if (i_state.tick_count >= i_cfg.display_ticks) begin
                        o_state.phase      = mkld_pkg::PH_IDLE;
                        o_state.tick_count = '0;
                    end else begin
                        o_state.tick_count = w_bumped;
                        o_result.lamp_b    = i_state.display_lamp;
                        o_result.lamp_a    = !i_state.display_lamp;
                    end
                end
                default: begin
                    // idle: hold
                end
            endcase
        end
    end

endmodule

/* hw/rtl/mkld_checker.sv */
`timescale 1ns / 1ps

module mkld_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        pready
);

    // found only together with done
    a_found_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[3])
        else $error("letter_found without letter_done");

    // a nonzero index needs a match, and stays within the alphabet
    a_index_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[9:5] != 5'd0) |->
            m_axis_tdata[4] && (m_axis_tdata[9:5] <= 5'd25))
        else $error("letter_index without match or out of range");

    // while the key is held exactly one lamp is lit and no letter ends
    a_press_lamps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |->
            (m_axis_tdata[1] != m_axis_tdata[2]) && !m_axis_tdata[3])
        else $error("press result shows bad lamps");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind morse_key_letter_decoder mkld_checker u_mkld_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);
